// ===== sv/hsteq_pkg.sv =====
// shared types and constants of the histogram equalizer
package hsteq_pkg;

   // gray pixel width and table output width
   localparam int PIXEL_W = 8;
   localparam int QUOT_W  = 8;
   localparam int QIDX_W  = $clog2(QUOT_W);

   // controller states
   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CNT_RD,
      ST_CNT_WR,
      ST_SCAN,
      ST_SCAN_END,
      ST_PREP,
      ST_BUILD_RD,
      ST_BUILD_ACC,
      ST_BUILD_NUM,
      ST_DIV,
      ST_BUILD_WR,
      ST_MAP_RD,
      ST_MAP_OUT
   } hsteq_state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic accept;
      logic bin_rd_item;
      logic scan_rd;
      logic build_rd;
      logic bin_wr_inc;
      logic bin_wr_zero;
      logic scan_start;
      logic prep;
      logic cdf_acc;
      logic num_load;
      logic div_step;
      logic tbl_wr;
      logic tbl_rd;
      logic out_load;
      logic cnt_inc;
   } hsteq_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic cnt_last;
      logic div_last;
      logic item_last;
      logic out_free;
   } hsteq_stat_type;

endpackage

// ===== sv/hsteq_channels.sv =====
// request and response channel interfaces of the histogram equalizer
interface hsteq_req_if;
   import hsteq_pkg::*;

   logic               valid;
   logic               ready;
   logic               command;
   logic [PIXEL_W-1:0] pixel;
   logic               last;

   modport source (output valid, output command, output pixel, output last, input ready);
   modport sink (input valid, input command, input pixel, input last, output ready);
endinterface

interface hsteq_rsp_if;
   import hsteq_pkg::*;

   logic               valid;
   logic               ready;
   logic [PIXEL_W-1:0] mapped_pixel;
   logic               end_of_frame;
   logic               flat_image;

   modport source (output valid, output mapped_pixel, output end_of_frame,
                   output flat_image, input ready);
   modport sink (input valid, input mapped_pixel, input end_of_frame,
                 input flat_image, output ready);
endinterface

// ===== sv/histogram_equalizer_core.sv =====
// top level of the two-pass histogram equalizer
// Pixels come in one at a time: command 0 counts a pixel into a LEVELS-bin
// histogram with bins saturating at MAX_PIXELS, command 1 maps it through the
// equalization table and gives one result. The time from a pixel's transfer to
// the next ready is set by the read-modify-write of the bin memory and the
// registered table read; a mapped result sits in an output register so the
// next pixel can be taken while it waits. The counted pixel with last set
// starts a table build: one sweep sums the bins, then each level takes a
// read, a cdf add, a numerator step and the bit-serial divider before its
// table write. After reset and after the mapped pixel with last set, a
// clearing pass zeroes the histogram; no pixel is taken during a build or a
// clearing pass.
module histogram_equalizer_core #(
   parameter int LEVELS     = 256,
   parameter int MAX_PIXELS = 1048576
) (
   input  logic         clock,
   input  logic         reset,
   hsteq_req_if.sink    req_chan,
   hsteq_rsp_if.source  rsp_chan
);
   import hsteq_pkg::*;

   hsteq_cmd_type  cmd;
   hsteq_stat_type stat;

   // controller
   hsteq_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_chan.valid),
      .req_command (req_chan.command),
      .stat        (stat),
      .req_ready   (req_chan.ready),
      .cmd         (cmd)
   );

   // datapath
   hsteq_dp #(
      .LEVELS     (LEVELS),
      .MAX_PIXELS (MAX_PIXELS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_pixel        (req_chan.pixel),
      .req_last         (req_chan.last),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_valid        (rsp_chan.valid),
      .rsp_ready        (rsp_chan.ready),
      .rsp_mapped_pixel (rsp_chan.mapped_pixel),
      .rsp_end_of_frame (rsp_chan.end_of_frame),
      .rsp_flat_image   (rsp_chan.flat_image)
   );

   // a counted pixel is written back in the write state that follows its bin read
   a_count_writeback: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && !req_chan.command) |-> ##2 cmd.bin_wr_inc)
      else $error("count pixel not written back");

   // a mapped pixel reads the table in the cycle after its transfer
   a_map_read: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && req_chan.command) |=> cmd.tbl_rd)
      else $error("map pixel did not read the table");

   // no input is taken while a sweep or the divider is running
   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      req_chan.ready |-> !(cmd.tbl_wr || cmd.bin_wr_zero || cmd.div_step || cmd.scan_rd))
      else $error("ready during table build or clearing pass");

endmodule

// ===== sv/hsteq_ctrl.sv =====
// controller state machine of the histogram equalizer
module hsteq_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_command,
   input  hsteq_pkg::hsteq_stat_type stat,
   output logic                     req_ready,
   output hsteq_pkg::hsteq_cmd_type  cmd
);
   import hsteq_pkg::*;

   hsteq_state_type state_ff;
   hsteq_state_type state_in;

   // state register, reset starts with a clearing sweep of the bins
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (stat.cnt_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = req_command ? ST_MAP_RD : ST_CNT_RD;
         end
         ST_CNT_RD: begin
            state_in = ST_CNT_WR;
         end
         ST_CNT_WR: begin
            state_in = stat.item_last ? ST_SCAN : ST_IDLE;
         end
         ST_SCAN: begin
            if (stat.cnt_last) state_in = ST_SCAN_END;
         end
         ST_SCAN_END: begin
            state_in = ST_PREP;
         end
         ST_PREP: begin
            state_in = ST_BUILD_RD;
         end
         ST_BUILD_RD: begin
            state_in = ST_BUILD_ACC;
         end
         ST_BUILD_ACC: begin
            state_in = ST_BUILD_NUM;
         end
         ST_BUILD_NUM: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (stat.div_last) state_in = ST_BUILD_WR;
         end
         ST_BUILD_WR: begin
            state_in = stat.cnt_last ? ST_IDLE : ST_BUILD_RD;
         end
         ST_MAP_RD: begin
            state_in = ST_MAP_OUT;
         end
         ST_MAP_OUT: begin
            if (stat.out_free) state_in = stat.item_last ? ST_CLEAR : ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // command outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.bin_wr_zero = 1'b1;
            cmd.cnt_inc     = 1'b1;
         end
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         ST_CNT_RD: begin
            cmd.bin_rd_item = 1'b1;
         end
         ST_CNT_WR: begin
            cmd.bin_wr_inc = 1'b1;
            cmd.scan_start = stat.item_last;
         end
         ST_SCAN: begin
            cmd.scan_rd = 1'b1;
            cmd.cnt_inc = 1'b1;
         end
         ST_SCAN_END: begin
            cmd = '0;
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
         end
         ST_BUILD_RD: begin
            cmd.build_rd = 1'b1;
         end
         ST_BUILD_ACC: begin
            cmd.cdf_acc = 1'b1;
         end
         ST_BUILD_NUM: begin
            cmd.num_load = 1'b1;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
         end
         ST_BUILD_WR: begin
            cmd.tbl_wr  = 1'b1;
            cmd.cnt_inc = 1'b1;
         end
         ST_MAP_RD: begin
            cmd.tbl_rd = 1'b1;
         end
         ST_MAP_OUT: begin
            cmd.out_load = stat.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// ===== sv/hsteq_dp.sv =====
// datapath of the histogram equalizer: bin and table memories, sums, divider
module hsteq_dp #(
   parameter int LEVELS     = 256,
   parameter int MAX_PIXELS = 1048576
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [hsteq_pkg::PIXEL_W-1:0]       req_pixel,
   input  logic                                req_last,
   input  hsteq_pkg::hsteq_cmd_type             cmd,
   output hsteq_pkg::hsteq_stat_type            stat,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [hsteq_pkg::PIXEL_W-1:0]       rsp_mapped_pixel,
   output logic                                rsp_end_of_frame,
   output logic                                rsp_flat_image
);
   import hsteq_pkg::*;

   localparam int IDX_W = $clog2(LEVELS);
   localparam int XW    = (IDX_W > PIXEL_W) ? IDX_W : PIXEL_W;
   localparam int BIN_W = $clog2(MAX_PIXELS + 1);
   localparam int TOT_W = $clog2(longint'(LEVELS) * longint'(MAX_PIXELS) + longint'(1));
   localparam int NUM_W = TOT_W + QUOT_W;
   localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(LEVELS - 1);
   localparam logic [XW-1:0]     LAST_EXT = XW'(LEVELS - 1);
   localparam logic [BIN_W-1:0]  BIN_MAX  = BIN_W'(MAX_PIXELS);

   logic [XW-1:0]     pix_ext;
   logic [IDX_W-1:0]  pix_idx;
   logic [IDX_W-1:0]  item_idx_ff;
   logic              item_last_ff;
   logic [IDX_W-1:0]  cnt_ff;

   logic [BIN_W-1:0]  bin_mem [LEVELS];
   logic [BIN_W-1:0]  bin_rdata_ff;
   logic [IDX_W-1:0]  bin_raddr;
   logic              bin_re;
   logic              bin_we;
   logic [IDX_W-1:0]  bin_waddr;
   logic [BIN_W-1:0]  bin_wdata;

   logic [QUOT_W-1:0] tbl_mem [LEVELS];
   logic [QUOT_W-1:0] tbl_rdata_ff;

   logic              scan_pend_ff;
   logic [TOT_W-1:0]  total_ff;
   logic [TOT_W-1:0]  cmin_ff;
   logic              seen_ff;
   logic              single_ff;
   logic [TOT_W-1:0]  span_ff;
   logic [TOT_W-1:0]  cdf_ff;
   logic [TOT_W-1:0]  diff;
   logic [NUM_W-1:0]  rem_ff;
   logic [NUM_W-1:0]  trial;
   logic [QUOT_W-1:0] quot_ff;
   logic [QIDX_W-1:0] div_k_ff;

   logic              out_valid_ff;
   logic [PIXEL_W-1:0] out_pixel_ff;
   logic              out_eof_ff;
   logic              out_flat_ff;

   // pixel to bin index, levels above the top bin fold into it
   always_comb begin
      pix_ext = XW'(req_pixel);
      if (pix_ext >= LAST_EXT) begin
         pix_idx = LAST_IDX;
      end else begin
         pix_idx = pix_ext[IDX_W-1:0];
      end
   end

   // item capture on input transfer
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         item_idx_ff  <= pix_idx;
         item_last_ff <= req_last;
      end
   end

   // sweep counter over all levels, wraps after the top level
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.cnt_inc) begin
         cnt_ff <= (cnt_ff == LAST_IDX) ? '0 : cnt_ff + IDX_W'(1);
      end
   end

   // bin memory port selection, saturating increment
   always_comb begin
      bin_re    = cmd.bin_rd_item | cmd.scan_rd | cmd.build_rd;
      bin_raddr = cmd.bin_rd_item ? item_idx_ff : cnt_ff;
      bin_we    = cmd.bin_wr_inc | cmd.bin_wr_zero;
      bin_waddr = cmd.bin_wr_inc ? item_idx_ff : cnt_ff;
      if (!cmd.bin_wr_inc) begin
         bin_wdata = '0;
      end else if (bin_rdata_ff == BIN_MAX) begin
         bin_wdata = bin_rdata_ff;
      end else begin
         bin_wdata = bin_rdata_ff + BIN_W'(1);
      end
   end

   // bin memory
   always_ff @(posedge clock) begin
      if (bin_we) bin_mem[bin_waddr] <= bin_wdata;
      if (bin_re) bin_rdata_ff <= bin_mem[bin_raddr];
   end

   // level table memory
   always_ff @(posedge clock) begin
      if (cmd.tbl_wr) tbl_mem[cnt_ff] <= single_ff ? '0 : quot_ff;
      if (cmd.tbl_rd) tbl_rdata_ff <= tbl_mem[item_idx_ff];
   end

   // scan read pending, data lands in the cycle after the read
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_pend_ff <= 1'b0;
      end else begin
         scan_pend_ff <= cmd.scan_rd;
      end
   end

   // total count and count of the smallest present level
   always_ff @(posedge clock) begin
      if (cmd.scan_start) begin
         total_ff <= '0;
         cmin_ff  <= '0;
         seen_ff  <= 1'b0;
      end else if (scan_pend_ff) begin
         total_ff <= total_ff + TOT_W'(bin_rdata_ff);
         if (!seen_ff && (bin_rdata_ff != '0)) begin
            cmin_ff <= TOT_W'(bin_rdata_ff);
            seen_ff <= 1'b1;
         end
      end
   end

   // single level flag, kept until the next table build
   always_ff @(posedge clock) begin
      if (reset) begin
         single_ff <= 1'b0;
      end else if (cmd.prep) begin
         single_ff <= (total_ff <= cmin_ff);
      end
   end

   // span and running cdf
   always_ff @(posedge clock) begin
      if (cmd.prep) begin
         span_ff <= total_ff - cmin_ff;
         cdf_ff  <= '0;
      end else if (cmd.cdf_acc) begin
         cdf_ff <= cdf_ff + TOT_W'(bin_rdata_ff);
      end
   end

   // numerator (cdf - cdf_min) * 255 as a shift and subtract
   assign diff  = (cdf_ff > cmin_ff) ? (cdf_ff - cmin_ff) : '0;
   assign trial = NUM_W'(span_ff) << div_k_ff;

   // restoring divider, one quotient bit per cycle, msb first
   always_ff @(posedge clock) begin
      if (cmd.num_load) begin
         rem_ff   <= (NUM_W'(diff) << QUOT_W) - NUM_W'(diff);
         quot_ff  <= '0;
         div_k_ff <= QIDX_W'(QUOT_W - 1);
      end else if (cmd.div_step) begin
         if (rem_ff >= trial) begin
            rem_ff  <= rem_ff - trial;
            quot_ff <= {quot_ff[QUOT_W-2:0], 1'b1};
         end else begin
            quot_ff <= {quot_ff[QUOT_W-2:0], 1'b0};
         end
         div_k_ff <= div_k_ff - QIDX_W'(1);
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_pixel_ff <= PIXEL_W'(tbl_rdata_ff);
         out_eof_ff   <= item_last_ff;
         out_flat_ff  <= single_ff;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_mapped_pixel = out_pixel_ff;
   assign rsp_end_of_frame = out_eof_ff;
   assign rsp_flat_image   = out_flat_ff;

   // status to controller
   always_comb begin
      stat.cnt_last  = (cnt_ff == LAST_IDX);
      stat.div_last  = (div_k_ff == '0);
      stat.item_last = item_last_ff;
      stat.out_free  = !out_valid_ff || rsp_ready;
   end

endmodule

// ===== bench/histogram_equalizer_core_tb.sv =====
// testbench for the histogram equalizer core: random two-pass frames checked against a predictor
module histogram_equalizer_core_tb;
   import hsteq_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int LEVELS        = 256;
   localparam int MAX_PIXELS    = 1048576;
   localparam int RANDOM_ITEMS  = 1100;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 14 * LEVELS + 64;
   localparam int CYCLE_LIMIT   = 1000000;

   // pixel commands
   localparam logic CMD_COUNT = 1'b0;
   localparam logic CMD_MAP   = 1'b1;

   // shapes of the gray-level distribution of a count pass
   typedef enum int {
      SPREAD_FULL,
      SPREAD_BAND,
      SPREAD_PAIR,
      SPREAD_ONE,
      SPREAD_EDGES
   } spread_kind_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] level;
      logic               end_of_frame;
      logic               flat_image;
   } mapped_result_type;

   // histogram, cdf table and queue of mapped pixels still to come
   class equalizer_predictor;
      logic [20:0]        bin_counts [LEVELS];
      logic [QUOT_W-1:0]  level_table [LEVELS];
      logic               single_level;
      mapped_result_type  pending_mapped [$];
      int                 mismatches;

      function new();
         foreach (bin_counts[v]) begin
            bin_counts[v]  = '0;
            level_table[v] = '0;
         end
         single_level = 1'b0;
         mismatches   = 0;
      endfunction

      function void note_pixel(logic command, logic [PIXEL_W-1:0] pixel, logic last);
         int unsigned       idx;
         longint unsigned   total;
         longint unsigned   cmin;
         longint unsigned   cdf;
         longint unsigned   span;
         longint unsigned   q;
         bit                seen;
         mapped_result_type res;

         idx = (pixel >= LEVELS) ? LEVELS - 1 : pixel;
         if (command == CMD_COUNT) begin
            // saturating bin increment
            if (bin_counts[idx] < MAX_PIXELS)
               bin_counts[idx] = bin_counts[idx] + 21'd1;
            if (last) begin
               // find the count of the lowest present level and the total
               total = 0;
               cmin  = 0;
               seen  = 1'b0;
               for (int v = 0; v < LEVELS; v++) begin
                  if (!seen && bin_counts[v] != 0) begin
                     cmin = 64'(bin_counts[v]);
                     seen = 1'b1;
                  end
                  total += 64'(bin_counts[v]);
               end
               if (total <= cmin) begin
                  // only one level present: all-zero table
                  single_level = 1'b1;
                  foreach (level_table[v])
                     level_table[v] = '0;
               end else begin
                  single_level = 1'b0;
                  span = total - cmin;
                  cdf  = 0;
                  for (int v = 0; v < LEVELS; v++) begin
                     cdf += 64'(bin_counts[v]);
                     q = (cdf <= cmin) ? 0 : ((cdf - cmin) * 255) / span;
                     if (q > 255)
                        q = 255;
                     level_table[v] = q[QUOT_W-1:0];
                  end
               end
            end
         end else begin
            res.level        = level_table[idx];
            res.end_of_frame = last;
            res.flat_image   = single_level;
            pending_mapped.push_back(res);
            // histogram cleared after the end of the map pass
            if (last) begin
               foreach (bin_counts[v])
                  bin_counts[v] = '0;
            end
         end
      endfunction

      function void check_mapped(logic [PIXEL_W-1:0] level, logic eof, logic flat);
         mapped_result_type want;

         if (pending_mapped.size() == 0) begin
            $display("%0t: unexpected result, mapped_pixel %0d end_of_frame %0b flat_image %0b",
                     $time, level, eof, flat);
            mismatches++;
            return;
         end
         want = pending_mapped.pop_front();
         if (level !== want.level) begin
            $display("%0t: mapped_pixel expected %0d actual %0d", $time, want.level, level);
            mismatches++;
         end
         if (eof !== want.end_of_frame) begin
            $display("%0t: end_of_frame expected %0b actual %0b", $time, want.end_of_frame, eof);
            mismatches++;
         end
         if (flat !== want.flat_image) begin
            $display("%0t: flat_image expected %0b actual %0b", $time, want.flat_image, flat);
            mismatches++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   hsteq_req_if req_bus ();
   hsteq_rsp_if rsp_bus ();

   equalizer_predictor predictor = new();

   int  send_idle_pct = 31;
   int  rcv_idle_pct  = 63;
   bit  hold_request  = 1'b0;
   int  hold_left     = 0;
   int  pixels_sent   = 0;
   int  cycle_count   = 0;

   histogram_equalizer_core #(
      .LEVELS     (LEVELS),
      .MAX_PIXELS (MAX_PIXELS)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // result transfers go to the predictor
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         predictor.check_mapped(rsp_bus.mapped_pixel, rsp_bus.end_of_frame,
                                rsp_bus.flat_image);
   end

   // receiver ready with random stalls and an occasional long hold-off
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= rcv_idle_pct);
         end
      end
   end

   // offer one pixel, entered and left at a falling edge
   task automatic send_pixel(logic command, logic [PIXEL_W-1:0] pixel, logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.command <= command;
      req_bus.pixel   <= pixel;
      req_bus.last    <= last;
      do
         @(posedge clock);
      while (!req_bus.ready);
      predictor.note_pixel(command, pixel, last);
      pixels_sent++;
      @(negedge clock);
   endtask

   // stop offering until every mapped pixel has come back
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      @(negedge clock);
      while (predictor.pending_mapped.size() != 0)
         @(negedge clock);
   endtask

   function automatic logic [PIXEL_W-1:0] pick_level(spread_kind_type spread,
                                                     logic [PIXEL_W-1:0] base,
                                                     logic [PIXEL_W-1:0] other);
      logic [PIXEL_W-1:0] level;

      case (spread)
         SPREAD_FULL:  level = PIXEL_W'($urandom_range(255));
         SPREAD_BAND:  level = base + PIXEL_W'($urandom_range(7));
         SPREAD_PAIR:  level = $urandom_range(1) ? base : other;
         SPREAD_ONE:   level = base;
         default: begin
            case ($urandom_range(2))
               0:       level = '0;
               1:       level = '1;
               default: level = PIXEL_W'($urandom_range(255));
            endcase
         end
      endcase
      return level;
   endfunction

   // count pass of n pixels, last set on the final one
   task automatic count_pass(int n, spread_kind_type spread);
      logic [PIXEL_W-1:0] base;
      logic [PIXEL_W-1:0] other;

      base  = PIXEL_W'($urandom_range(255));
      other = PIXEL_W'($urandom_range(255));
      for (int k = 0; k < n; k++)
         send_pixel(CMD_COUNT, pick_level(spread, base, other), k == n - 1);
   endtask

   // map pass of n pixels, optionally closed by last
   task automatic map_pass(int n, bit close);
      for (int k = 0; k < n; k++)
         send_pixel(CMD_MAP, PIXEL_W'($urandom_range(255)), close && (k == n - 1));
   endtask

   // random commands with an occasional last
   task automatic noise_burst(int n);
      for (int k = 0; k < n; k++)
         send_pixel(1'($urandom_range(1)), PIXEL_W'($urandom_range(255)),
                    $urandom_range(7) == 0);
   endtask

   task automatic directed_cases();
      // single pixel frame gives a flat table
      send_pixel(CMD_COUNT, 8'd0, 1'b1);
      send_pixel(CMD_MAP, 8'd0, 1'b0);
      send_pixel(CMD_MAP, 8'd255, 1'b1);
      // extreme levels, with absent levels in between
      send_pixel(CMD_COUNT, 8'd0, 1'b0);
      send_pixel(CMD_COUNT, 8'd255, 1'b0);
      send_pixel(CMD_COUNT, 8'd255, 1'b1);
      send_pixel(CMD_MAP, 8'd0, 1'b0);
      send_pixel(CMD_MAP, 8'd128, 1'b0);
      send_pixel(CMD_MAP, 8'd255, 1'b1);
      // one level repeated is flat too
      send_pixel(CMD_COUNT, 8'd7, 1'b0);
      send_pixel(CMD_COUNT, 8'd7, 1'b0);
      send_pixel(CMD_COUNT, 8'd7, 1'b1);
      // counts between map pixels add to the histogram and rebuild the table
      send_pixel(CMD_MAP, 8'd200, 1'b0);
      send_pixel(CMD_COUNT, 8'd10, 1'b0);
      send_pixel(CMD_COUNT, 8'd20, 1'b1);
      send_pixel(CMD_MAP, 8'd10, 1'b0);
      send_pixel(CMD_MAP, 8'd15, 1'b0);
      send_pixel(CMD_MAP, 8'd20, 1'b1);
      // table survives the clear of the histogram
      send_pixel(CMD_MAP, 8'd255, 1'b1);
   endtask

   task automatic random_traffic();
      int              random_start;
      int              frame_no;
      int              phase;
      int              last_phase;
      int              kind_roll;
      spread_kind_type spread;

      random_start = pixels_sent;
      frame_no     = 0;
      last_phase   = 0;
      while (pixels_sent - random_start < RANDOM_ITEMS) begin
         // idling mix changes by thirds, with a full drain at each change
         phase = (pixels_sent - random_start) * 3 / RANDOM_ITEMS;
         if (phase != last_phase) begin
            drain_results();
            send_idle_pct = (phase == 1) ? 63 : 0;
            rcv_idle_pct  = (phase == 1) ? 31 : 0;
            last_phase    = phase;
         end
         kind_roll = $urandom_range(99);
         spread    = spread_kind_type'($urandom_range(SPREAD_EDGES));
         if (kind_roll < 70) begin
            // well-formed frame, sometimes against a long receiver hold-off
            count_pass($urandom_range(1, 48), spread);
            if (frame_no % 9 == 4) begin
               // hold-off starts once the table build is over
               map_pass(1, 1'b0);
               hold_request = 1'b1;
               map_pass(47, 1'b1);
            end else begin
               map_pass($urandom_range(1, 48), 1'b1);
            end
         end else if (kind_roll < 80) begin
            // map again through the table of the previous frame
            map_pass($urandom_range(1, 32), 1'b1);
         end else if (kind_roll < 90) begin
            noise_burst($urandom_range(1, 8));
            map_pass($urandom_range(1, 16), $urandom_range(1));
         end else begin
            // two count passes accumulate before mapping
            count_pass($urandom_range(1, 24), spread);
            count_pass($urandom_range(1, 24), spread_kind_type'($urandom_range(SPREAD_EDGES)));
            map_pass($urandom_range(1, 32), 1'b1);
         end
         frame_no++;
      end
   endtask

   // reset, stimulus and final verdict
   initial begin
      reset           = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.command = CMD_COUNT;
      req_bus.pixel   = '0;
      req_bus.last    = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      directed_cases();
      random_traffic();
      drain_results();
      repeat (SETTLE_CYCLES) @(negedge clock);

      if (predictor.mismatches == 0 && predictor.pending_mapped.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
